// ----- hw/rtl/mrsb_pkg.sv -----
`timescale 1ns / 1ps

package mrsb_pkg;

   // Width of the candidate and base fields on the request word.
   localparam int DATA_W = 32;

   // Default operand width of the arithmetic.
   localparam int WIDTH_DEFAULT = 32;

   // Smallest candidate that is tested at all.
   localparam int MIN_CANDIDATE = 2;

   typedef struct packed {
      logic [DATA_W-1:0] candidate;
      logic [DATA_W-1:0] base;
   } req_type;

   typedef struct packed {
      logic probably_prime;
      logic input_invalid;
   } rsp_type;

endpackage

// ----- hw/rtl/miller_rabin_single_base.sv -----
`timescale 1ns / 1ps

// One Miller-Rabin round for a candidate p and a witness base a.
// A request word is taken at a rising edge where start is high and busy is
// low; only the low WIDTH bits of candidate and base are used. The block then
// stays busy until it has the answer, and shows the response word on rsp_data
// for exactly one cycle with rsp_valid high. The receiver cannot stall, so
// the response is gone after that cycle; busy is already low in it.
// A candidate below two is answered in the next cycle, with
// input_invalid set. Otherwise all work runs through one bit-serial modular
// multiplier: one product reduces the base, then the exponent
// m = (p - 1) / 2^k is scanned one bit a cycle while no product is pending,
// with a square and an optional multiply per bit after the leading one. If
// a^m mod p is 1 the answer is a pass; else at most k further squarings
// follow, each after a test against p - 1. One item is in work at a time.
// Reset returns the block to idle with no response pending.

module miller_rabin_single_base #(
   parameter int WIDTH = mrsb_pkg::WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mrsb_pkg::req_type req_data,
   output logic              rsp_valid,
   output mrsb_pkg::rsp_type rsp_data
);

   localparam int KW  = $clog2(WIDTH);
   localparam int ECW = $clog2(WIDTH + 1);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_REDUCE   = 8'b0000_0010,
      ST_POW_BIT  = 8'b0000_0100,
      ST_POW_SQ   = 8'b0000_1000,
      ST_POW_MUL  = 8'b0001_0000,
      ST_CHECK    = 8'b0010_0000,
      ST_FIN_TEST = 8'b0100_0000,
      ST_FIN_SQ   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [WIDTH-1:0]  p_ff, p_in;
   logic [WIDTH-1:0]  x_ff, x_in;
   logic [WIDTH-1:0]  m_ff, m_in;
   logic [WIDTH-1:0]  z_ff, z_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [ECW-1:0]    ecnt_ff, ecnt_in;
   logic              started_ff, started_in;
   logic              ebit_ff, ebit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mrsb_pkg::rsp_type rsp_ff, rsp_in;

   logic              accept;
   logic [WIDTH-1:0]  req_p;
   logic [WIDTH-1:0]  req_a;
   logic              req_small;
   logic              mul_start;
   logic [WIDTH-1:0]  mul_x;
   logic [WIDTH-1:0]  mul_y;
   logic [WIDTH-1:0]  mul_p;
   logic              mul_done;
   logic [WIDTH-1:0]  mul_res;
   logic [WIDTH-1:0]  p_minus_one;

   assign accept      = start && (state_ff == ST_IDLE);
   assign req_p       = WIDTH'(req_data.candidate);
   assign req_a       = WIDTH'(req_data.base);
   assign req_small   = req_p < WIDTH'(mrsb_pkg::MIN_CANDIDATE);
   assign p_minus_one = p_ff - WIDTH'(1);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      x_in         = x_ff;
      m_in         = m_ff;
      z_in         = z_ff;
      k_in         = k_ff;
      ecnt_in      = ecnt_ff;
      started_in   = started_ff;
      ebit_in      = ebit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_start    = 1'b0;
      mul_x        = z_ff;
      mul_y        = z_ff;
      mul_p        = p_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_small) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.probably_prime = 1'b0;
                  rsp_in.input_invalid  = 1'b1;
               end else begin
                  // Reduce the base as 1 * a mod p while p - 1 is split.
                  mul_start = 1'b1;
                  mul_x     = WIDTH'(1);
                  mul_y     = req_a;
                  mul_p     = req_p;
                  p_in      = req_p;
                  m_in      = req_p - WIDTH'(1);
                  k_in      = '0;
                  state_in  = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // p - 1 is nonzero, so the shifting stops well before the
            // product is ready.
            if (!m_ff[0]) begin
               m_in = {1'b0, m_ff[WIDTH-1:1]};
               k_in = k_ff + KW'(1);
            end
            if (mul_done) begin
               x_in       = mul_res;
               z_in       = WIDTH'(1);
               ecnt_in    = ECW'(WIDTH);
               started_in = 1'b0;
               state_in   = ST_POW_BIT;
            end
         end
         ST_POW_BIT: begin
            if (ecnt_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               m_in    = {m_ff[WIDTH-2:0], 1'b0};
               ecnt_in = ecnt_ff - ECW'(1);
               ebit_in = m_ff[WIDTH-1];
               if (started_ff) begin
                  mul_start = 1'b1;
                  state_in  = ST_POW_SQ;
               end else if (m_ff[WIDTH-1]) begin
                  // Leading one: 1 squared times x is x itself.
                  z_in       = x_ff;
                  started_in = 1'b1;
               end
            end
         end
         ST_POW_SQ: begin
            if (mul_done) begin
               z_in = mul_res;
               if (ebit_ff) begin
                  mul_start = 1'b1;
                  mul_x     = mul_res;
                  mul_y     = x_ff;
                  state_in  = ST_POW_MUL;
               end else begin
                  state_in = ST_POW_BIT;
               end
            end
         end
         ST_POW_MUL: begin
            if (mul_done) begin
               z_in     = mul_res;
               state_in = ST_POW_BIT;
            end
         end
         ST_CHECK: begin
            if (z_ff == WIDTH'(1)) begin
               rsp_valid_in          = 1'b1;
               rsp_in.probably_prime = 1'b1;
               rsp_in.input_invalid  = 1'b0;
               state_in              = ST_IDLE;
            end else begin
               state_in = ST_FIN_TEST;
            end
         end
         ST_FIN_TEST: begin
            if (k_ff == '0) begin
               rsp_valid_in          = 1'b1;
               rsp_in.probably_prime = 1'b0;
               rsp_in.input_invalid  = 1'b0;
               state_in              = ST_IDLE;
            end else if (z_ff == p_minus_one) begin
               rsp_valid_in          = 1'b1;
               rsp_in.probably_prime = 1'b1;
               rsp_in.input_invalid  = 1'b0;
               state_in              = ST_IDLE;
            end else begin
               mul_start = 1'b1;
               k_in      = k_ff - KW'(1);
               state_in  = ST_FIN_SQ;
            end
         end
         ST_FIN_SQ: begin
            if (mul_done) begin
               z_in     = mul_res;
               state_in = ST_FIN_TEST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff       <= p_in;
      x_ff       <= x_in;
      m_ff       <= m_in;
      z_ff       <= z_in;
      k_ff       <= k_in;
      ecnt_ff    <= ecnt_in;
      started_ff <= started_in;
      ebit_ff    <= ebit_in;
      rsp_ff     <= rsp_in;
   end

   mrsb_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_x   (mul_x),
      .op_y   (mul_y),
      .modulus(mul_p),
      .done   (mul_done),
      .result (mul_res)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A response is only ever issued on the way back to idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response issued while busy");

   // A taken request either starts work or is answered at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request was dropped");

   // The two flags never claim both an invalid input and a pass.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.probably_prime && rsp_data.input_invalid))
      else $error("invalid input reported as probable prime");

   // The multiplier finishes only while the controller waits for it.
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_REDUCE || state_ff == ST_POW_SQ ||
                    state_ff == ST_POW_MUL || state_ff == ST_FIN_SQ))
      else $error("product finished with no consumer");

endmodule

// ----- hw/rtl/mrsb_mulmod.sv -----
`timescale 1ns / 1ps

module mrsb_mulmod #(
   parameter int WIDTH = mrsb_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_x,
   input  logic [WIDTH-1:0] op_y,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] result
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] y_ff, y_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] dbl;
   logic [WIDTH-1:0] acc;

   // (a + b) mod m for a, b below m; the sum keeps its carry bit.
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      logic [WIDTH:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, m};
      return (s >= {1'b0, m}) ? d[WIDTH-1:0] : s[WIDTH-1:0];
   endfunction

   // One bit of the multiplier per cycle, most significant first.
   always_comb begin
      dbl = add_mod(r_ff, r_ff, p_ff);
      acc = y_ff[WIDTH-1] ? add_mod(dbl, x_ff, p_ff) : dbl;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      p_in    = p_ff;
      r_in    = r_ff;
      if (start) begin
         cnt_in = CW'(WIDTH);
         x_in   = op_x;
         y_in   = op_y;
         p_in   = modulus;
         r_in   = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CW'(1);
         y_in    = {y_ff[WIDTH-2:0], 1'b0};
         r_in    = acc;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      p_ff <= p_in;
      r_ff <= r_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

// ----- dv/miller_rabin_single_base_tb.sv -----
`timescale 1ns / 1ps

module miller_rabin_single_base_tb;

   localparam int WIDTH = mrsb_pkg::WIDTH_DEFAULT;
   localparam bit [63:0] OPERAND_MASK = {64{1'b1}} >> (64 - WIDTH);
   localparam int DRAIN_CYCLES = 2400;
   localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

   typedef struct {
      mrsb_pkg::req_type word;
      mrsb_pkg::rsp_type verdict;
   } pending_verdict_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   mrsb_pkg::req_type req_data;
   logic              rsp_valid;
   mrsb_pkg::rsp_type rsp_data;

   pending_verdict_type pending_verdicts[$];
   int error_count = 0;
   int sent_count = 0;
   int prime_count = 0;
   int composite_count = 0;
   int invalid_count = 0;
   int idle_percent = 0;

   miller_rabin_single_base #(
      .WIDTH(WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Products of two operands below p need twice the operand width.
   function automatic bit [63:0] mod_mul(bit [63:0] x, bit [63:0] y, bit [63:0] p);
      bit [127:0] prod;
      prod = x * y;
      return 64'(prod % p);
   endfunction

   function automatic bit [63:0] mod_pow(bit [63:0] x, bit [63:0] e, bit [63:0] p);
      bit [63:0] acc;
      int i;
      acc = 1;
      for (i = 63; i >= 0; i--) begin
         acc = mod_mul(acc, acc, p);
         if (e[i]) begin
            acc = mod_mul(acc, x, p);
         end
      end
      return acc;
   endfunction

   function automatic mrsb_pkg::rsp_type mr_verdict(mrsb_pkg::req_type w);
      bit [63:0] p;
      bit [63:0] a;
      bit [63:0] m;
      bit [63:0] b;
      int k;
      int i;
      mrsb_pkg::rsp_type v;
      p = 64'(w.candidate) & OPERAND_MASK;
      a = 64'(w.base) & OPERAND_MASK;
      v = '0;
      if (p < mrsb_pkg::MIN_CANDIDATE) begin
         v.input_invalid = 1'b1;
         return v;
      end
      m = p - 1;
      k = 0;
      while (m[0] == 1'b0) begin
         m = m >> 1;
         k++;
      end
      b = mod_pow(a % p, m, p);
      if (b == 1) begin
         v.probably_prime = 1'b1;
      end else begin
         for (i = 0; i < k; i++) begin
            if (b == p - 1) begin
               v.probably_prime = 1'b1;
               break;
            end
            b = mod_mul(b, b, p);
         end
      end
      return v;
   endfunction

   // Passing several small bases is good enough to pick prime candidates.
   function automatic bit passes_small_bases(logic [mrsb_pkg::DATA_W-1:0] p);
      int unsigned bases[5] = '{2, 3, 5, 7, 11};
      mrsb_pkg::req_type w;
      mrsb_pkg::rsp_type v;
      int i;
      for (i = 0; i < 5; i++) begin
         w.candidate = p;
         w.base = bases[i];
         v = mr_verdict(w);
         if (!v.probably_prime) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   task automatic send_word(input logic [mrsb_pkg::DATA_W-1:0] candidate,
                            input logic [mrsb_pkg::DATA_W-1:0] base);
      mrsb_pkg::req_type w;
      pending_verdict_type entry;
      w.candidate = candidate;
      w.base = base;
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      entry.word = w;
      entry.verdict = mr_verdict(w);
      pending_verdicts.insert(pending_verdicts.size(), entry);
      sent_count++;
      if (idle_percent > 0 && $urandom_range(1, 100) <= idle_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      pending_verdict_type entry;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, got %b/%b",
                     $time, rsp_data.probably_prime, rsp_data.input_invalid);
            error_count++;
         end else begin
            entry = pending_verdicts.pop_front();
            if (rsp_data.probably_prime !== entry.verdict.probably_prime) begin
               $display("%0t: probably_prime for p=%0d a=%0d: expected %b, got %b",
                        $time, entry.word.candidate, entry.word.base,
                        entry.verdict.probably_prime, rsp_data.probably_prime);
               error_count++;
            end
            if (rsp_data.input_invalid !== entry.verdict.input_invalid) begin
               $display("%0t: input_invalid for p=%0d a=%0d: expected %b, got %b",
                        $time, entry.word.candidate, entry.word.base,
                        entry.verdict.input_invalid, rsp_data.input_invalid);
               error_count++;
            end
            if (entry.verdict.input_invalid) begin
               invalid_count++;
            end else if (entry.verdict.probably_prime) begin
               prime_count++;
            end else begin
               composite_count++;
            end
         end
      end
   end

   task automatic test_invalid_candidates();
      send_word(32'd0, 32'd0);
      send_word(32'd0, 32'hFFFF_FFFF);
      send_word(32'd1, 32'd1);
      send_word(32'd1, 32'h1234_5678);
   endtask

   // With p = 2 the answer depends only on whether the base is odd.
   task automatic test_candidate_two();
      send_word(32'd2, 32'd1);
      send_word(32'd2, 32'd2);
      send_word(32'd2, 32'd3);
      send_word(32'd2, 32'd0);
      send_word(32'd2, 32'hFFFF_FFFF);
   endtask

   task automatic test_even_candidates();
      send_word(32'd4, 32'd1);
      send_word(32'd4, 32'd3);
      send_word(32'hFFFF_FFFE, 32'd3);
      send_word(32'h8000_0000, 32'hFFFF_FFFF);
   endtask

   task automatic test_base_multiple();
      send_word(32'd7, 32'd0);
      send_word(32'd7, 32'd14);
      send_word(32'd4294967291, 32'd0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Large primes, strong pseudoprimes and a Carmichael number.
   task automatic test_extremes_and_pseudoprimes();
      send_word(32'd4294967291, 32'd2);
      send_word(32'd4294967291, 32'hFFFF_FFFF);
      send_word(32'd2047, 32'd2);
      send_word(32'd561, 32'd2);
      send_word(32'd3215031751, 32'd2);
      send_word(32'd3, 32'd2);
      send_word(32'd65537, 32'd3);
   endtask

   task automatic send_random_word();
      logic [mrsb_pkg::DATA_W-1:0] p;
      logic [mrsb_pkg::DATA_W-1:0] a;
      int kind;
      int shift;
      kind = $urandom_range(0, 9);
      a = $urandom;
      case (kind)
         0, 1, 2, 3: begin
            do begin
               p = $urandom | 32'd1;
            end while (p < 3 || !passes_small_bases(p));
         end
         4, 5: begin
            // Many factors of two in p - 1 give a long squaring tail.
            shift = $urandom_range(1, 30);
            p = ({$urandom} << shift) | 32'd1;
         end
         6: begin
            p = $urandom_range(2, 2000);
            a = $urandom_range(0, 3000);
         end
         7: begin
            p = $urandom;
         end
         8: begin
            case ($urandom_range(0, 3))
               0: p = 32'd2047;
               1: p = 32'd1373653;
               2: p = 32'd25326001;
               default: p = 32'd3215031751;
            endcase
            if ($urandom_range(0, 1) == 0) begin
               a = 2;
            end
         end
         default: begin
            p = $urandom;
            case ($urandom_range(0, 2))
               0: p = $urandom_range(0, 1);
               1: a = p * $urandom_range(0, 3);
               default: a = p - 1;
            endcase
         end
      endcase
      send_word(p, a);
   endtask

   task automatic test_random_mix(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 20 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_percent = 0;
               1: idle_percent = 30;
               default: idle_percent = 70;
            endcase
         end
         send_random_word();
      end
   endtask

   task automatic test_back_to_back(input int count);
      int i;
      idle_percent = 0;
      for (i = 0; i < count; i++) begin
         send_random_word();
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_percent = 40;
      test_invalid_candidates();
      test_candidate_two();
      test_even_candidates();
      test_base_multiple();
      test_extremes_and_pseudoprimes();
      test_random_mix(126);
      test_back_to_back(30);
      start <= 1'b0;

      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d probable primes, %0d composites, %0d invalid candidates.",
               sent_count, prime_count, composite_count, invalid_count);
      $display("Included prime and pseudoprime candidates, long squaring tails and bursts.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d responses outstanding.", pending_verdicts.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mrsb_pkg.sv
hw/rtl/mrsb_mulmod.sv
hw/rtl/miller_rabin_single_base.sv
dv/miller_rabin_single_base_tb.sv
